@@ hw/rtl/tga_pkg.sv @@
// tga decoder package: request types, status codes and control structs
`timescale 1ns / 1ps

package tga_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STAT_SEGMENT    = 2'd0,
    STAT_BAD_TYPE   = 2'd1,
    STAT_BAD_FORMAT = 2'd2,
    STAT_BAD_SIZE   = 2'd3
  } status_e;

  // input request: one byte of the file stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_req_t;

  // output request: one row segment or one status report
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] dest_row;
    logic [11:0] start_column;
    logic [7:0]  pixel_count;
    status_e     status;
    logic        image_done;
    logic        last_of_input;
  } out_req_t;

  // commands from controller to datapath
  typedef struct packed {
    logic restart;     // first byte of a new file
    logic hdr_byte;    // capture a header byte
    logic err_out;     // post a status report
    logic skip_dec;    // one id byte skipped
    logic start_data;  // clear pixel position and color assembly
    logic pkt_load;    // take an rle packet header
    logic pkt_dec;     // one raw pixel of a packet used
    logic col_byte;    // take one color byte
    logic place_new;   // place the pixel just assembled
    logic place_held;  // place the rest of a held run
    logic use_held;    // segment logic works on the held run
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic    hdr_last;
    status_e hdr_err;
    logic    id_zero;
    logic    skip_one;
    logic    kind_rle;
    logic    pix_last;
    logic    pkt_run;
    logic    pkt_le1;
    logic    seg_final;
    logic    rest_zero;
    logic    slot_free;
  } stat_t;

endpackage

@@ hw/rtl/tga_ctrl.sv @@
// tga decoder controller: parse phase state machine and input handshake
`timescale 1ns / 1ps

module tga_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           first_byte_i,
  input  tga_pkg::stat_t stat_i,
  output logic           in_stall_o,
  output tga_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    ST_HEADER = 7'b0000001,
    ST_SKIP   = 7'b0000010,
    ST_PKT    = 7'b0000100,
    ST_PIX    = 7'b0001000,
    ST_EMIT   = 7'b0010000,
    ST_DONE   = 7'b0100000,
    ST_ERR    = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  state_e        place_next;
  state_e        start_next;
  logic          place_pkt_dec;
  logic          accept;
  tga_pkg::cmd_t cmd;

  // input is held off while a run is split or the output slot is full
  assign in_stall_o = (state_q == ST_EMIT) || !stat_i.slot_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign start_next = stat_i.kind_rle ? ST_PKT : ST_PIX;

  // where to go once a segment is placed
  always_comb begin
    place_pkt_dec = 1'b0;
    if (stat_i.seg_final) begin
      place_next = ST_DONE;
    end else if (!stat_i.rest_zero) begin
      place_next = ST_EMIT;
    end else if (stat_i.kind_rle) begin
      if (stat_i.pkt_run || stat_i.pkt_le1) begin
        place_next = ST_PKT;
      end else begin
        place_next    = ST_PIX;
        place_pkt_dec = 1'b1;
      end
    end else begin
      place_next = ST_PIX;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd          = '0;
    cmd.use_held = (state_q == ST_EMIT);
    if (accept) begin
      if (first_byte_i || state_q == ST_HEADER) begin
        cmd.hdr_byte = 1'b1;
        cmd.restart  = first_byte_i;
        state_d      = ST_HEADER;
        if (!first_byte_i && stat_i.hdr_last) begin
          if (stat_i.hdr_err != tga_pkg::STAT_SEGMENT) begin
            cmd.err_out = 1'b1;
            state_d     = ST_ERR;
          end else if (!stat_i.id_zero) begin
            state_d = ST_SKIP;
          end else begin
            cmd.start_data = 1'b1;
            state_d        = start_next;
          end
        end
      end else begin
        unique case (state_q)
          ST_SKIP: begin
            cmd.skip_dec = 1'b1;
            if (stat_i.skip_one) begin
              cmd.start_data = 1'b1;
              state_d        = start_next;
            end
          end
          ST_PKT: begin
            cmd.pkt_load = 1'b1;
            state_d      = ST_PIX;
          end
          ST_PIX: begin
            cmd.col_byte = 1'b1;
            if (stat_i.pix_last) begin
              cmd.place_new = 1'b1;
              cmd.pkt_dec   = place_pkt_dec;
              state_d       = place_next;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (state_q == ST_EMIT && stat_i.slot_free) begin
      cmd.place_held = 1'b1;
      cmd.pkt_dec    = place_pkt_dec;
      state_d        = place_next;
    end
  end

  assign cmd_o = cmd;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/tga_dp.sv @@
// tga decoder datapath: header fields, color assembly, row split and output register
`timescale 1ns / 1ps

module tga_dp #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tga_pkg::in_req_t  in_data_i,
  input  tga_pkg::cmd_t     cmd_i,
  input  logic              out_stall_i,
  output tga_pkg::stat_t    stat_o,
  output logic              out_valid_o,
  output tga_pkg::out_req_t out_data_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam logic [4:0] HdrId      = 5'd0;
  localparam logic [4:0] HdrMap     = 5'd1;
  localparam logic [4:0] HdrType    = 5'd2;
  localparam logic [4:0] HdrWidthLo = 5'd12;
  localparam logic [4:0] HdrWidthHi = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrBpp     = 5'd16;
  localparam logic [4:0] HdrLast    = 5'd17;

  localparam logic [7:0]  TypeRaw     = 8'd2;
  localparam logic [7:0]  TypeRle     = 8'd10;
  localparam logic [7:0]  Bpp24       = 8'd24;
  localparam logic [7:0]  Bpp32       = 8'd32;
  localparam logic [15:0] MinWidth    = 16'd4;
  localparam logic [7:0]  AlphaOpaque = 8'd255;
  localparam logic [7:0]  MaxRun      = 8'd128;

  // control registers
  logic [4:0]      hdr_idx_q, hdr_idx_d;
  logic [7:0]      id_skip_q, id_skip_d;
  logic            pkt_run_q, pkt_run_d;
  logic [7:0]      pkt_left_q, pkt_left_d;
  logic [1:0]      cidx_q, cidx_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [7:0]      run_left_q, run_left_d;
  logic            out_valid_q, out_valid_d;

  // payload registers
  logic [7:0]        map_kind_q, map_kind_d;
  logic [7:0]        image_kind_q, image_kind_d;
  logic [7:0]        bpp_q, bpp_d;
  logic [15:0]       width_q, width_d;
  logic [15:0]       height_q, height_d;
  logic [23:0]       cbytes_q, cbytes_d;
  logic [31:0]       run_color_q, run_color_d;
  tga_pkg::out_req_t out_q, out_d;

  logic [7:0]       d;
  logic [4:0]       hdr_idx_eff;
  logic             is32;
  logic [1:0]       last_idx;
  logic [31:0]      new_color;
  logic [7:0]       new_count;
  logic [31:0]      cur_color;
  logic [7:0]       cur_count;
  logic [15:0]      room;
  logic             wrap;
  logic [7:0]       take;
  logic [7:0]       rest;
  logic             row_last;
  logic [15:0]      col_sum;
  logic [15:0]      dest_row16;
  logic [15:0]      col16;
  logic             size_bad;
  logic             slot_free;
  tga_pkg::status_e hdr_err;

  assign d           = in_data_i.data_byte;
  assign hdr_idx_eff = cmd_i.restart ? HdrId : hdr_idx_q;

  // header check, by priority: type, then format or colormap, then size
  assign size_bad = (width_q < MinWidth) || (width_q > 16'(MAX_WIDTH)) ||
                    (height_q == 16'd0) || (height_q > 16'(MAX_HEIGHT));

  always_comb begin
    if (image_kind_q != TypeRaw && image_kind_q != TypeRle) begin
      hdr_err = tga_pkg::STAT_BAD_TYPE;
    end else if (map_kind_q != 8'd0 || (bpp_q != Bpp24 && bpp_q != Bpp32)) begin
      hdr_err = tga_pkg::STAT_BAD_FORMAT;
    end else if (size_bad) begin
      hdr_err = tga_pkg::STAT_BAD_SIZE;
    end else begin
      hdr_err = tga_pkg::STAT_SEGMENT;
    end
  end

  // pixel assembly from b, g, r (, a) byte order
  assign is32      = (bpp_q == Bpp32);
  assign last_idx  = is32 ? 2'd3 : 2'd2;
  assign new_color = {is32 ? cbytes_q[23:16] : d, cbytes_q[15:8], cbytes_q[7:0],
                      is32 ? d : AlphaOpaque};
  assign new_count = (image_kind_q == TypeRle && pkt_run_q) ? pkt_left_q : 8'd1;

  // row split of the current run
  assign cur_color  = cmd_i.use_held ? run_color_q : new_color;
  assign cur_count  = cmd_i.use_held ? run_left_q : new_count;
  assign col16      = 16'(col_q);
  assign room       = width_q - col16;
  assign wrap       = (16'(cur_count) >= room);
  assign take       = wrap ? room[7:0] : cur_count;
  assign rest       = cur_count - take;
  assign row_last   = ((16'(row_q) + 16'd1) == height_q);
  assign col_sum    = col16 + 16'(take);
  assign dest_row16 = height_q - 16'd1 - 16'(row_q);

  assign slot_free = !out_valid_q || !out_stall_i;

  // status toward the controller
  always_comb begin
    stat_o           = '0;
    stat_o.hdr_last  = (hdr_idx_q == HdrLast);
    stat_o.hdr_err   = hdr_err;
    stat_o.id_zero   = (id_skip_q == 8'd0);
    stat_o.skip_one  = (id_skip_q <= 8'd1);
    stat_o.kind_rle  = (image_kind_q == TypeRle);
    stat_o.pix_last  = (cidx_q == last_idx);
    stat_o.pkt_run   = pkt_run_q;
    stat_o.pkt_le1   = (pkt_left_q <= 8'd1);
    stat_o.seg_final = wrap && row_last;
    stat_o.rest_zero = (rest == 8'd0);
    stat_o.slot_free = slot_free;
  end

  // next values
  always_comb begin
    hdr_idx_d    = hdr_idx_q;
    id_skip_d    = id_skip_q;
    pkt_run_d    = pkt_run_q;
    pkt_left_d   = pkt_left_q;
    cidx_d       = cidx_q;
    col_d        = col_q;
    row_d        = row_q;
    run_left_d   = run_left_q;
    map_kind_d   = map_kind_q;
    image_kind_d = image_kind_q;
    bpp_d        = bpp_q;
    width_d      = width_q;
    height_d     = height_q;
    cbytes_d     = cbytes_q;
    run_color_d  = run_color_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    // header capture
    if (cmd_i.hdr_byte) begin
      hdr_idx_d = (hdr_idx_eff == HdrLast) ? 5'd0 : hdr_idx_eff + 5'd1;
      unique case (hdr_idx_eff)
        HdrId:       id_skip_d    = d;
        HdrMap:      map_kind_d   = d;
        HdrType:     image_kind_d = d;
        HdrWidthLo:  width_d      = {8'd0, d};
        HdrWidthHi:  width_d      = {d, width_q[7:0]};
        HdrHeightLo: height_d     = {8'd0, d};
        HdrHeightHi: height_d     = {d, height_q[7:0]};
        HdrBpp:      bpp_d        = d;
        default: begin
        end
      endcase
    end

    // id skip
    if (cmd_i.skip_dec && id_skip_q != 8'd0) begin
      id_skip_d = id_skip_q - 8'd1;
    end

    // start of pixel data
    if (cmd_i.start_data) begin
      cidx_d   = 2'd0;
      cbytes_d = 24'd0;
      col_d    = '0;
      row_d    = '0;
    end

    // rle packet header
    if (cmd_i.pkt_load) begin
      pkt_run_d  = d[7];
      pkt_left_d = {1'b0, d[6:0]} + 8'd1;
      cidx_d     = 2'd0;
      cbytes_d   = 24'd0;
    end
    if (cmd_i.pkt_dec) begin
      pkt_left_d = pkt_left_q - 8'd1;
    end

    // color byte collection
    if (cmd_i.col_byte) begin
      cidx_d = cidx_q + 2'd1;
      case (cidx_q)
        2'd0:    cbytes_d[7:0]   = d;
        2'd1:    cbytes_d[15:8]  = d;
        2'd2:    cbytes_d[23:16] = d;
        default: begin
        end
      endcase
    end

    // segment placement
    if (cmd_i.place_new || cmd_i.place_held) begin
      if (cmd_i.place_new) begin
        cidx_d   = 2'd0;
        cbytes_d = 24'd0;
      end
      run_color_d = cur_color;
      run_left_d  = rest;
      col_d       = wrap ? '0 : col_sum[ColW-1:0];
      if (wrap && !row_last) begin
        row_d = row_q + RowW'(1);
      end
      out_d.red           = cur_color[31:24];
      out_d.green         = cur_color[23:16];
      out_d.blue          = cur_color[15:8];
      out_d.alpha         = cur_color[7:0];
      out_d.dest_row      = dest_row16[11:0];
      out_d.start_column  = col16[11:0];
      out_d.pixel_count   = take;
      out_d.status        = tga_pkg::STAT_SEGMENT;
      out_d.image_done    = wrap && row_last;
      out_d.last_of_input = (rest == 8'd0) || (wrap && row_last);
      out_valid_d         = 1'b1;
    end

    // header status report
    if (cmd_i.err_out) begin
      out_d               = '0;
      out_d.status        = hdr_err;
      out_d.last_of_input = 1'b1;
      out_valid_d         = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q   <= '0;
      id_skip_q   <= '0;
      pkt_run_q   <= 1'b0;
      pkt_left_q  <= '0;
      cidx_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      run_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_idx_q   <= hdr_idx_d;
      id_skip_q   <= id_skip_d;
      pkt_run_q   <= pkt_run_d;
      pkt_left_q  <= pkt_left_d;
      cidx_q      <= cidx_d;
      col_q       <= col_d;
      row_q       <= row_d;
      run_left_q  <= run_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    map_kind_q   <= map_kind_d;
    image_kind_q <= image_kind_d;
    bpp_q        <= bpp_d;
    width_q      <= width_d;
    height_q     <= height_d;
    cbytes_q     <= cbytes_d;
    run_color_q  <= run_color_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a posted segment always carries 1 to 128 pixels
  a_seg_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == tga_pkg::STAT_SEGMENT |->
      out_q.pixel_count != 8'd0 && out_q.pixel_count <= MaxRun)
    else $error("segment pixel count out of range");

  // a status report is empty and closes its byte
  a_err_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != tga_pkg::STAT_SEGMENT |->
      out_q.pixel_count == 8'd0 && out_q.last_of_input && !out_q.image_done)
    else $error("malformed status report");

  // the final segment of an image is the last one of its byte
  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.image_done |-> out_q.last_of_input)
    else $error("image done without last of input");

  // a held run never exceeds one packet
  a_run_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_left_q <= MaxRun)
    else $error("held run longer than a packet");

endmodule

@@ hw/rtl/tga_rle_image_decoder_top.sv @@
// A result is in the output register in the cycle after the byte that completes it.
// Throughput: one byte per cycle unless held; a run split over k rows holds the input while its
// later segments go out, one per cycle when the output is free, from the shared row split logic.
// The input is also held while the output register is full and stalled.
// Reset (rst_ni, async, active low): parser in header phase at byte 0, output register empty.
`timescale 1ns / 1ps

module tga_rle_image_decoder_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tga_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tga_pkg::out_req_t out_data_o
);

  tga_pkg::cmd_t  cmd;
  tga_pkg::stat_t stat;

  // phase controller
  tga_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .first_byte_i (in_data_i.first_byte),
    .stat_i       (stat),
    .in_stall_o   (in_stall_o),
    .cmd_o        (cmd)
  );

  // header, pixel and segment datapath
  tga_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/tb.sv @@
// testbench for the tga rle image decoder: byte streams checked against a decoder model
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FRAME_MAX_W  = 4096;
  localparam int unsigned FRAME_MAX_H  = 4096;
  localparam int unsigned FRAME_MIN_W  = 4;
  localparam int unsigned RANDOM_BYTES = 40;

  // tga image type and pixel depth codes
  localparam logic [7:0] KIND_RAW = 8'd2;
  localparam logic [7:0] KIND_RLE = 8'd10;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // header byte offsets
  localparam int HDR_ID_LEN   = 0;
  localparam int HDR_MAP_KIND = 1;
  localparam int HDR_IMG_KIND = 2;
  localparam int HDR_W_LO     = 12;
  localparam int HDR_W_HI     = 13;
  localparam int HDR_H_LO     = 14;
  localparam int HDR_H_HI     = 15;
  localparam int HDR_DEPTH    = 16;
  localparam int HDR_LAST     = 17;

  // parser state of the model
  typedef enum logic [2:0] {
    P_HDR, P_ID, P_PKT_HDR, P_COLOR, P_END, P_FAULT
  } parse_state_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  tga_pkg::in_req_t   in_data_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tga_pkg::out_req_t  out_data_o;

  tga_rle_image_decoder_top #(
    .MAX_WIDTH (FRAME_MAX_W),
    .MAX_HEIGHT(FRAME_MAX_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // model state
  parse_state_e dec_phase;
  logic [4:0]   hdr_pos;
  logic [7:0]   id_left;
  logic [7:0]   img_kind;
  logic [7:0]   map_kind;
  logic [7:0]   pix_depth;
  logic [15:0]  img_w;
  logic [15:0]  img_h;
  logic         run_pkt;
  logic [7:0]   pkt_count;
  logic [1:0]   col_idx;
  logic [23:0]  col_acc;
  logic [11:0]  row_in_file;
  int unsigned  col_pos;

  tga_pkg::out_req_t byte_results[$];
  tga_pkg::out_req_t expected_segments[$];
  logic [7:0]        file_bytes[$];

  int unsigned       errors = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       bytes_decoded = 0;
  int unsigned       results_checked = 0;
  int unsigned       status_reports = 0;
  int unsigned       burst_left = 0;
  bit                bursty = 1'b1;
  logic [9:0]        stall_cyc = '0;
  tga_pkg::out_req_t want;

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  function automatic void clear_decoder();
    dec_phase   = P_HDR;
    hdr_pos     = '0;
    id_left     = '0;
    img_kind    = '0;
    map_kind    = '0;
    pix_depth   = '0;
    img_w       = '0;
    img_h       = '0;
    run_pkt     = 1'b0;
    pkt_count   = '0;
    col_idx     = '0;
    col_acc     = '0;
    row_in_file = '0;
    col_pos     = 0;
  endfunction

  function automatic void begin_pixels();
    col_idx = '0;
    col_acc = '0;
    dec_phase = (img_kind == KIND_RLE) ? P_PKT_HDR : P_COLOR;
  endfunction

  // lay cnt equal pixels from the current position, one segment per row touched
  task automatic lay_run(input int unsigned cnt, input logic [7:0] r, input logic [7:0] g,
                         input logic [7:0] b, input logic [7:0] a);
    int unsigned       room;
    int unsigned       take;
    tga_pkg::out_req_t seg;
    while (cnt > 0 && dec_phase != P_END) begin
      room = int'(img_w) - col_pos;
      take = (cnt < room) ? cnt : room;
      seg = '0;
      seg.red          = r;
      seg.green        = g;
      seg.blue         = b;
      seg.alpha        = a;
      seg.dest_row     = 12'(int'(img_h) - 1 - int'(row_in_file));
      seg.start_column = 12'(col_pos);
      seg.pixel_count  = 8'(take);
      seg.status       = tga_pkg::STAT_SEGMENT;
      col_pos = col_pos + take;
      cnt = cnt - take;
      if (col_pos >= int'(img_w)) begin
        col_pos = 0;
        if (int'(row_in_file) + 1 >= int'(img_h)) begin
          seg.image_done = 1'b1;
          dec_phase = P_END;
        end else begin
          row_in_file = row_in_file + 12'd1;
        end
      end
      byte_results.push_back(seg);
    end
  endtask

  // advance the model by one accepted byte and queue what it produces
  task automatic decode_byte(input logic [7:0] d, input logic f, output bit taken);
    tga_pkg::status_e  verdict;
    logic [1:0]        top_idx;
    logic [1:0]        idx;
    int unsigned       cnt;
    logic [7:0]        r, g, b, a;
    tga_pkg::out_req_t rpt;
    byte_results.delete();
    if (f) clear_decoder();
    taken = (dec_phase != P_END) && (dec_phase != P_FAULT);
    case (dec_phase)
      P_HDR: begin
        case (int'(hdr_pos))
          HDR_ID_LEN:   id_left = d;
          HDR_MAP_KIND: map_kind = d;
          HDR_IMG_KIND: img_kind = d;
          HDR_W_LO:     img_w = {8'h00, d};
          HDR_W_HI:     img_w[15:8] = d;
          HDR_H_LO:     img_h = {8'h00, d};
          HDR_H_HI:     img_h[15:8] = d;
          HDR_DEPTH:    pix_depth = d;
          default: ;
        endcase
        if (int'(hdr_pos) < HDR_LAST) begin
          hdr_pos = hdr_pos + 5'd1;
        end else begin
          hdr_pos = '0;
          verdict = tga_pkg::STAT_SEGMENT;
          if (img_kind != KIND_RAW && img_kind != KIND_RLE) begin
            verdict = tga_pkg::STAT_BAD_TYPE;
          end else if (map_kind != 8'd0 || (pix_depth != DEPTH_24 && pix_depth != DEPTH_32)) begin
            verdict = tga_pkg::STAT_BAD_FORMAT;
          end else if (int'(img_w) < FRAME_MIN_W || int'(img_w) > FRAME_MAX_W ||
                       img_h == 16'd0 || int'(img_h) > FRAME_MAX_H) begin
            verdict = tga_pkg::STAT_BAD_SIZE;
          end
          if (verdict != tga_pkg::STAT_SEGMENT) begin
            rpt = '0;
            rpt.status = verdict;
            byte_results.push_back(rpt);
            dec_phase = P_FAULT;
            status_reports++;
          end else if (id_left != 8'd0) begin
            dec_phase = P_ID;
          end else begin
            begin_pixels();
          end
        end
      end
      P_ID: begin
        if (id_left != 8'd0) id_left = id_left - 8'd1;
        if (id_left == 8'd0) begin_pixels();
      end
      P_PKT_HDR: begin
        run_pkt   = d[7];
        pkt_count = {1'b0, d[6:0]} + 8'd1;
        col_idx   = '0;
        col_acc   = '0;
        dec_phase = P_COLOR;
      end
      P_COLOR: begin
        top_idx = (pix_depth == DEPTH_32) ? 2'd3 : 2'd2;
        idx = col_idx;
        if (idx != 2'd3) col_acc = col_acc | (24'(d) << (8 * idx));
        if (idx < top_idx) begin
          col_idx = idx + 2'd1;
        end else begin
          b = col_acc[7:0];
          g = col_acc[15:8];
          r = col_acc[23:16];
          a = (top_idx == 2'd3) ? d : 8'hFF;
          col_idx = '0;
          col_acc = '0;
          cnt = 1;
          if (img_kind == KIND_RLE && run_pkt) cnt = 32'(pkt_count);
          lay_run(cnt, r, g, b, a);
          if (img_kind == KIND_RLE && dec_phase != P_END) begin
            if (run_pkt || pkt_count <= 8'd1) begin
              pkt_count = '0;
              dec_phase = P_PKT_HDR;
            end else begin
              pkt_count = pkt_count - 8'd1;
            end
          end
        end
      end
      default: ;
    endcase
    // mark the final result of this byte
    foreach (byte_results[k]) begin
      rpt = byte_results[k];
      rpt.last_of_input = (k == byte_results.size() - 1);
      expected_segments.push_back(rpt);
    end
  endtask

  // send one byte request, with bursts and gaps on the sender side
  task automatic send_byte(input logic [7:0] d, input logic f);
    int unsigned gap;
    bit          taken;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {d, f};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(d, f, taken);
    bytes_sent++;
    if (taken) bytes_decoded++;
    @(negedge clk_i);
  endtask

  // hold the sender off until every expected result is out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_segments.size() != 0) @(negedge clk_i);
  endtask

  // send the next count bytes of the prepared file
  task automatic send_file(input bit first, input int count);
    for (int k = 0; k < count && file_bytes.size() > 0; k++) begin
      send_byte(file_bytes.pop_front(), first && (k == 0));
    end
  endtask

  task automatic push_header(input logic [7:0] id_len, input logic [7:0] map_k,
                             input logic [7:0] kind, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth);
    file_bytes.push_back(id_len);
    file_bytes.push_back(map_k);
    file_bytes.push_back(kind);
    // color map spec and origin carry random filler
    repeat (9) file_bytes.push_back(rand8());
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(depth);
    file_bytes.push_back(rand8());
  endtask

  task automatic push_pixel(input logic [7:0] depth, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    file_bytes.push_back(b);
    file_bytes.push_back(g);
    file_bytes.push_back(r);
    if (depth == DEPTH_32) file_bytes.push_back(a);
  endtask

  task automatic push_rand_pixel(input logic [7:0] depth);
    push_pixel(depth, rand8(), rand8(), rand8(), rand8());
  endtask

  task automatic push_packet(input bit run, input int unsigned n);
    file_bytes.push_back({run, 7'(n - 1)});
  endtask

  // header that must be refused, followed by a byte that is ignored
  task automatic send_bad_header(input logic [7:0] kind, input logic [7:0] map_k,
                                 input logic [15:0] w, input logic [15:0] h,
                                 input logic [7:0] depth);
    push_header(8'd0, map_k, kind, w, h, depth);
    file_bytes.push_back(rand8());
    send_file(1'b1, file_bytes.size());
  endtask

  // header bytes straight after reset without the first byte marker
  task automatic test_after_reset();
    push_header(8'd0, 8'd0, KIND_RAW, 16'd4, 16'd1, DEPTH_24);
    repeat (2) begin
      push_pixel(DEPTH_24, 8'hFF, 8'h00, 8'hFF, 8'h00);
      push_pixel(DEPTH_24, 8'h00, 8'hFF, 8'h00, 8'h00);
    end
    // trailing bytes after completion
    repeat (2) file_bytes.push_back(rand8());
    send_file(1'b0, file_bytes.size());
  endtask

  // order in which header faults are reported, and the width bound
  task automatic test_header_errors();
    send_bad_header(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_bad_header(KIND_RAW, 8'd1, 16'd2, 16'd0, 8'd16);
    send_bad_header(KIND_RLE, 8'd0, 16'd4097, 16'd4, DEPTH_32);
  endtask

  // id skip, runs across rows, raw packet and a run past the last pixel
  task automatic test_rle_rows();
    push_header(8'd3, 8'd0, KIND_RLE, 16'd5, 16'd3, DEPTH_32);
    repeat (3) file_bytes.push_back(rand8());
    push_packet(1'b1, 7);
    push_rand_pixel(DEPTH_32);
    push_packet(1'b0, 3);
    repeat (3) push_rand_pixel(DEPTH_32);
    push_packet(1'b1, 128);
    push_pixel(DEPTH_32, 8'h00, 8'hFF, 8'h00, 8'hFF);
    repeat (2) file_bytes.push_back(rand8());
    send_file(1'b1, 18);
    wait_drained();
    send_file(1'b0, file_bytes.size());
  endtask

  // restart by first byte in the middle of a header, then a whole file
  task automatic test_restart();
    push_header(8'd0, 8'd0, KIND_RLE, 16'd4, 16'd1, DEPTH_24);
    send_file(1'b1, 10);
    file_bytes.delete();
    push_header(8'd0, 8'd0, KIND_RLE, 16'd4, 16'd1, DEPTH_24);
    push_packet(1'b1, 4);
    push_rand_pixel(DEPTH_24);
    send_file(1'b1, file_bytes.size());
  endtask

  // largest height and largest width
  task automatic test_extreme_sizes();
    // narrow and full height, one run split over many rows
    push_header(8'd0, 8'd0, KIND_RLE, 16'd4, 16'd4096, DEPTH_24);
    push_packet(1'b0, 2);
    repeat (2) push_rand_pixel(DEPTH_24);
    push_packet(1'b1, 128);
    push_rand_pixel(DEPTH_24);
    send_file(1'b1, file_bytes.size());
    // full width, two runs along the first row, left unfinished
    push_header(8'd0, 8'd0, KIND_RLE, 16'd4096, 16'd2, DEPTH_32);
    repeat (2) begin
      push_packet(1'b1, 128);
      push_rand_pixel(DEPTH_32);
    end
    send_file(1'b1, file_bytes.size());
  endtask

  // well-formed file with random content, sometimes cut short
  task automatic send_random_file();
    logic [7:0]  kind, depth, id_len;
    int unsigned w, h, left, n, cut;
    bit          run;
    kind   = $urandom_range(0, 2) != 0 ? KIND_RLE : KIND_RAW;
    depth  = $urandom_range(0, 1) != 0 ? DEPTH_32 : DEPTH_24;
    w      = $urandom_range(FRAME_MIN_W, 7);
    h      = $urandom_range(1, 3);
    id_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
    push_header(id_len, 8'd0, kind, 16'(w), 16'(h), depth);
    repeat (id_len) file_bytes.push_back(rand8());
    left = w * h;
    if (kind == KIND_RAW) begin
      repeat (left) push_rand_pixel(depth);
    end else begin
      while (left > 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, left);
        run = 1'($urandom_range(0, 1));
        push_packet(run, n);
        if (run) push_rand_pixel(depth);
        else repeat (n) push_rand_pixel(depth);
        left = (n >= left) ? 0 : left - n;
      end
    end
    cut = file_bytes.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, file_bytes.size() - 1);
    send_file(1'b1, cut);
    file_bytes.delete();
  endtask

  // header with fields that are often, not always, out of range
  task automatic send_random_header();
    logic [7:0]  kind, map_k, depth;
    logic [15:0] w, h;
    case ($urandom_range(0, 2))
      0: kind = rand8();
      1: kind = KIND_RAW;
      default: kind = KIND_RLE;
    endcase
    map_k = ($urandom_range(0, 3) == 0) ? rand8() : 8'd0;
    case ($urandom_range(0, 3))
      0: depth = rand8();
      1: depth = DEPTH_24;
      2: depth = DEPTH_32;
      default: depth = 8'd16;
    endcase
    case ($urandom_range(0, 3))
      0: w = 16'($urandom);
      1: w = 16'($urandom_range(0, 3));
      2: w = 16'($urandom_range(4097, 65535));
      default: w = 16'($urandom_range(4, 7));
    endcase
    case ($urandom_range(0, 2))
      0: h = 16'd0;
      1: h = 16'($urandom);
      default: h = 16'($urandom_range(1, 3));
    endcase
    push_header(8'd0, map_k, kind, w, h, depth);
    repeat ($urandom_range(0, 3)) file_bytes.push_back(rand8());
    send_file(1'b1, file_bytes.size());
  endtask

  // random mix: mostly whole files, some broken headers and noise
  task automatic test_random_files();
    int unsigned start;
    int unsigned pick;
    start = bytes_decoded;
    while (bytes_decoded - start < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_random_file();
      end else if (pick < 82) begin
        send_random_header();
      end else begin
        repeat ($urandom_range(1, 8)) file_bytes.push_back(rand8());
        send_file($urandom_range(0, 7) == 0, file_bytes.size());
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
      bursty = $urandom_range(0, 4) != 0;
    end
    bursty = 1'b1;
  endtask

  // receiver stall pattern: free, light, heavy, periodic
  always @(negedge clk_i) begin
    stall_cyc <= stall_cyc + 10'd1;
    case (stall_cyc[7:6])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_cyc[2:0] < 3'd3);
    endcase
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // compare each accepted result request with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_segments.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        want = expected_segments.pop_front();
        check_field("red", want.red, out_data_o.red);
        check_field("green", want.green, out_data_o.green);
        check_field("blue", want.blue, out_data_o.blue);
        check_field("alpha", want.alpha, out_data_o.alpha);
        check_field("dest_row", want.dest_row, out_data_o.dest_row);
        check_field("start_column", want.start_column, out_data_o.start_column);
        check_field("pixel_count", want.pixel_count, out_data_o.pixel_count);
        check_field("status", want.status, out_data_o.status);
        check_field("image_done", want.image_done, out_data_o.image_done);
        check_field("last_of_input", want.last_of_input, out_data_o.last_of_input);
        results_checked++;
      end
    end
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    clear_decoder();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_after_reset();
    test_header_errors();
    test_rle_rows();
    test_restart();
    test_extreme_sizes();
    test_random_files();

    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("%0d bytes sent, %0d decoded, %0d results checked, %0d status reports",
             bytes_sent, bytes_decoded, results_checked, status_reports);
    $display("raw and rle files, 24 and 32 bit pixels, header faults, id skip, row splits, restarts");
    if (errors == 0 && expected_segments.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
